### rtl/ajrb_pkg.sv
`default_nettype none

package ajrb_pkg;

  // ring geometry default
  localparam int RING_DEPTH_DEF = 16384;

  // register reset values
  localparam logic [14:0] PREBUF_THR_RST = 15'd3200;
  localparam logic [14:0] NOM_LEN_RST    = 15'd640;
  localparam logic [7:0]  MAX_CONCEAL_RST = 8'd25;
  localparam logic [19:0] UNDERRUN_LIM_RST = 20'd8000;

  localparam logic [19:0] RUN_MAX = 20'hFFFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // configuration register indexes
  localparam logic [1:0] REG_PREBUF_THR   = 2'd0;
  localparam logic [1:0] REG_NOM_LEN      = 2'd1;
  localparam logic [1:0] REG_MAX_CONCEAL  = 2'd2;
  localparam logic [1:0] REG_UNDERRUN_LIM = 2'd3;

  typedef enum logic [2:0] {
    ACT_HEADER   = 3'd0,
    ACT_SAMPLE   = 3'd1,
    ACT_PULL     = 3'd2,
    ACT_CLOSE    = 3'd3,
    ACT_OPEN     = 3'd4,
    ACT_TAKE_EXC = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIL_CHECK,
    ST_SIL_WRITE
  } state_t;

  typedef struct packed {
    logic [14:0] buffered;
    logic        prebuf_ready;
    logic [15:0] free_bytes;
  } status_t;

endpackage

`default_nettype wire

### rtl/ajrb_ram.sv
`default_nettype none

module ajrb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = ajrb_pkg::RING_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/ajrb_status.sv
`default_nettype none

module ajrb_status #(
  parameter int RING_DEPTH = ajrb_pkg::RING_DEPTH_DEF
) (
  input  wire logic [$clog2(RING_DEPTH):0] fill,
  input  wire logic                        open,
  input  wire logic [14:0]                 threshold,
  output ajrb_pkg::status_t                status
);

  localparam int FW = $clog2(RING_DEPTH) + 1;
  localparam int CW = ((FW > 15) ? FW : 15) + 1;
  localparam int BW = ((FW + 1) > 16) ? (FW + 1) : 16;

  logic [FW-1:0] free_s;
  logic [FW:0]   fb_wide;
  logic [BW-1:0] fb_ext;

  always_comb begin
    free_s  = open ? (FW'(RING_DEPTH) - fill) : '0;
    fb_wide = {free_s, 1'b0};
    fb_ext  = BW'(fb_wide);
    status.buffered     = 15'(fill);
    status.prebuf_ready = (CW'(fill) >= CW'(threshold));
    // free space in bytes, clipped to 16 bits
    status.free_bytes   = (fb_ext > BW'(16'hFFFF)) ? 16'hFFFF : fb_ext[15:0];
  end

endmodule

`default_nettype wire

### rtl/audio_jitter_ring_buffer.sv
// Timing: a result strobes in the cycle after its word is taken; a header that conceals a
//   gap strobes once the SIL_CHECK/SIL_WRITE loop has written the silence frames that fit.
// Throughput: one word per cycle while busy is low; busy holds off words during such headers
//   (one silence sample per cycle through the single ring write port); pulls use the registered RAM read.
// Reset: synchronous, active low; control state cleared, ring closed, registers to defaults.
//   Ring contents stay undefined: there is no clearing pass. The receiver cannot stall.
`default_nettype none

module audio_jitter_ring_buffer #(
  parameter int RING_DEPTH = ajrb_pkg::RING_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_action,
  input  wire logic [15:0]        in_seq,
  input  wire logic [14:0]        in_frame_len,
  input  wire logic signed [15:0] in_sample_in,
  // result channel
  output logic                    out_strobe,
  output logic signed [15:0]      out_sample_out,
  output logic                    out_sample_valid,
  output logic                    out_end_of_stream,
  output logic                    out_push_accepted,
  output logic [14:0]             out_buffered_samples,
  output logic                    out_prebuffer_ready,
  output logic [15:0]             out_free_bytes,
  output logic [15:0]             out_underrun_events,
  output logic                    out_underrun_exceeded,
  // configuration write channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [19:0]        cfg_data
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int FW = AW + 1;
  localparam int CW = ((FW > 15) ? FW : 15) + 1;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  ajrb_pkg::state_t state_r, state_nxt;

  logic          open_r,      open_nxt;
  logic          closing_r,   closing_nxt;
  logic          taking_r,    taking_nxt;
  logic          seq_seen_r,  seq_seen_nxt;
  logic [15:0]   next_seq_r,  next_seq_nxt;
  logic [FW-1:0] fill_r,      fill_nxt;
  logic [AW-1:0] rp_r,        rp_nxt;
  logic [AW-1:0] wp_r,        wp_nxt;
  logic [14:0]   remain_r,    remain_nxt;
  logic          urun_on_r,   urun_on_nxt;
  logic [19:0]   urun_r,      urun_nxt;
  logic [15:0]   ucount_r,    ucount_nxt;
  logic          exc_latch_r, exc_latch_nxt;

  // concealment sequencer
  logic [7:0]    frames_r,    frames_nxt;
  logic [14:0]   silcnt_r,    silcnt_nxt;
  logic [14:0]   flen_r,      flen_nxt;

  // result word
  logic          strobe_r,    strobe_nxt;
  logic          valid_r,     valid_nxt;
  logic          eos_r,       eos_nxt;
  logic          acc_r,       acc_nxt;
  logic          exc_rep_r,   exc_rep_nxt;
  logic          pull_hit_r,  pull_hit_nxt;

  // configuration
  logic [14:0]   thr_r;
  logic [14:0]   nom_r;
  logic [7:0]    maxc_r;
  logic [19:0]   ulim_r;

  // ring RAM port
  logic          ram_we;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [15:0]   ram_rdata;

  // ---------------------------------------------------------------------------
  // Shared arithmetic
  // ---------------------------------------------------------------------------
  logic [15:0]   seq_diff;
  logic [7:0]    missing;
  logic          gap_go;
  logic [14:0]   hdr_len;
  logic          hdr_fit;
  logic          nom_fit;
  logic          sil_done;
  logic          sample_ok;
  logic [AW-1:0] rp_inc;
  logic [AW-1:0] wp_inc;
  logic [19:0]   run_base;
  logic [19:0]   run_new;
  logic [14:0]   remain_after;

  always_comb begin
    // 16-bit modular gap to the expected sequence; first header only learns it
    seq_diff = in_seq - next_seq_r;
    missing  = (seq_seen_r && (seq_diff <= {8'd0, maxc_r})) ? seq_diff[7:0] : 8'd0;
    gap_go   = (missing != 8'd0) && (nom_r != 15'd0);

    // header length comes from the port at accept, from the stash after concealment
    hdr_len  = (state_r == ajrb_pkg::ST_IDLE) ? in_frame_len : flen_r;
    hdr_fit  = (hdr_len != 15'd0) && ((CW'(fill_r) + CW'(hdr_len)) <= CW'(RING_DEPTH));
    nom_fit  = (CW'(fill_r) + CW'(nom_r)) <= CW'(RING_DEPTH);
    // once a silence frame misses, later ones miss too: fill does not move
    sil_done = (frames_r == 8'd0) || !nom_fit;

    sample_ok = open_r && !closing_r && taking_r && (remain_r != 15'd0) &&
                (fill_r < FW'(RING_DEPTH));
    remain_after = sample_ok ? (remain_r - 15'd1) : remain_r;

    rp_inc = (rp_r == AW'(RING_DEPTH - 1)) ? '0 : (rp_r + AW'(1));
    wp_inc = (wp_r == AW'(RING_DEPTH - 1)) ? '0 : (wp_r + AW'(1));

    run_base = urun_on_r ? urun_r : 20'd0;
    run_new  = (run_base != ajrb_pkg::RUN_MAX) ? (run_base + 20'd1) : run_base;
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ajrb_pkg::ST_IDLE: begin
        if (start && (in_action == ajrb_pkg::ACT_HEADER) && open_r && !closing_r && gap_go) begin
          state_nxt = ajrb_pkg::ST_SIL_CHECK;
        end
      end
      ajrb_pkg::ST_SIL_CHECK: begin
        state_nxt = sil_done ? ajrb_pkg::ST_IDLE : ajrb_pkg::ST_SIL_WRITE;
      end
      ajrb_pkg::ST_SIL_WRITE: begin
        if (silcnt_r == 15'd1) begin
          state_nxt = ajrb_pkg::ST_SIL_CHECK;
        end
      end
      default: begin
        state_nxt = ajrb_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and result
  // ---------------------------------------------------------------------------
  always_comb begin
    open_nxt      = open_r;
    closing_nxt   = closing_r;
    taking_nxt    = taking_r;
    seq_seen_nxt  = seq_seen_r;
    next_seq_nxt  = next_seq_r;
    fill_nxt      = fill_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    remain_nxt    = remain_r;
    urun_on_nxt   = urun_on_r;
    urun_nxt      = urun_r;
    ucount_nxt    = ucount_r;
    exc_latch_nxt = exc_latch_r;
    frames_nxt    = frames_r;
    silcnt_nxt    = silcnt_r;
    flen_nxt      = flen_r;
    strobe_nxt    = 1'b0;
    valid_nxt     = 1'b0;
    eos_nxt       = 1'b0;
    acc_nxt       = 1'b0;
    pull_hit_nxt  = 1'b0;
    exc_rep_nxt   = exc_rep_r;
    ram_we        = 1'b0;
    ram_wdata     = 16'd0;
    ram_re        = 1'b0;

    case (state_r)
      ajrb_pkg::ST_IDLE: begin
        if (start) begin
          strobe_nxt = 1'b1;
          case (in_action)
            ajrb_pkg::ACT_HEADER: begin
              if (open_r) begin
                seq_seen_nxt = 1'b1;
                next_seq_nxt = in_seq + 16'd1;
                if (!closing_r) begin
                  // a new header drops what is left of the old frame
                  taking_nxt = 1'b0;
                  remain_nxt = 15'd0;
                  if (gap_go) begin
                    strobe_nxt = 1'b0;
                    frames_nxt = missing;
                    flen_nxt   = in_frame_len;
                  end else if (hdr_fit) begin
                    taking_nxt = 1'b1;
                    remain_nxt = in_frame_len;
                    acc_nxt    = 1'b1;
                  end
                end
              end
            end
            ajrb_pkg::ACT_SAMPLE: begin
              if (sample_ok) begin
                ram_we    = 1'b1;
                ram_wdata = $unsigned(in_sample_in);
                wp_nxt    = wp_inc;
                fill_nxt  = fill_r + FW'(1);
                acc_nxt   = 1'b1;
              end
              remain_nxt = remain_after;
              if (remain_after == 15'd0) begin
                taking_nxt = 1'b0;
              end
            end
            ajrb_pkg::ACT_PULL: begin
              if (open_r) begin
                if (fill_r != '0) begin
                  ram_re       = 1'b1;
                  rp_nxt       = rp_inc;
                  fill_nxt     = fill_r - FW'(1);
                  valid_nxt    = 1'b1;
                  pull_hit_nxt = 1'b1;
                  urun_on_nxt  = 1'b0;
                  urun_nxt     = 20'd0;
                end else if (closing_r) begin
                  eos_nxt = 1'b1;
                end else begin
                  // empty and open: silence, one underrun step per sample
                  valid_nxt   = 1'b1;
                  urun_on_nxt = 1'b1;
                  if (!urun_on_r && (ucount_r != ajrb_pkg::COUNT_MAX)) begin
                    ucount_nxt = ucount_r + 16'd1;
                  end
                  urun_nxt = run_new;
                  if (run_new >= ulim_r) begin
                    exc_latch_nxt = 1'b1;
                  end
                end
              end
            end
            ajrb_pkg::ACT_CLOSE: begin
              if (open_r) begin
                closing_nxt = 1'b1;
                taking_nxt  = 1'b0;
                remain_nxt  = 15'd0;
              end
            end
            ajrb_pkg::ACT_OPEN: begin
              open_nxt      = 1'b1;
              closing_nxt   = 1'b0;
              taking_nxt    = 1'b0;
              seq_seen_nxt  = 1'b0;
              next_seq_nxt  = 16'd0;
              fill_nxt      = '0;
              rp_nxt        = '0;
              wp_nxt        = '0;
              remain_nxt    = 15'd0;
              urun_on_nxt   = 1'b0;
              urun_nxt      = 20'd0;
              ucount_nxt    = 16'd0;
              exc_latch_nxt = 1'b0;
            end
            ajrb_pkg::ACT_TAKE_EXC: begin
              exc_latch_nxt = 1'b0;
            end
            default: begin
            end
          endcase
          // take-exceeded reports the flag as held before clearing
          exc_rep_nxt = (in_action == ajrb_pkg::ACT_TAKE_EXC) ? exc_latch_r : exc_latch_nxt;
        end
      end
      ajrb_pkg::ST_SIL_CHECK: begin
        if (sil_done) begin
          // concealment over: settle the announced frame and report
          frames_nxt  = 8'd0;
          strobe_nxt  = 1'b1;
          exc_rep_nxt = exc_latch_r;
          if (hdr_fit) begin
            taking_nxt = 1'b1;
            remain_nxt = flen_r;
            acc_nxt    = 1'b1;
          end
        end else begin
          silcnt_nxt = nom_r;
        end
      end
      ajrb_pkg::ST_SIL_WRITE: begin
        ram_we     = 1'b1;
        ram_wdata  = 16'd0;
        wp_nxt     = wp_inc;
        fill_nxt   = fill_r + FW'(1);
        silcnt_nxt = silcnt_r - 15'd1;
        if (silcnt_r == 15'd1) begin
          frames_nxt = frames_r - 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ajrb_pkg::ST_IDLE;
      open_r      <= 1'b0;
      closing_r   <= 1'b0;
      taking_r    <= 1'b0;
      seq_seen_r  <= 1'b0;
      next_seq_r  <= 16'd0;
      fill_r      <= '0;
      rp_r        <= '0;
      wp_r        <= '0;
      remain_r    <= 15'd0;
      urun_on_r   <= 1'b0;
      urun_r      <= 20'd0;
      ucount_r    <= 16'd0;
      exc_latch_r <= 1'b0;
      frames_r    <= 8'd0;
      strobe_r    <= 1'b0;
      valid_r     <= 1'b0;
      eos_r       <= 1'b0;
      acc_r       <= 1'b0;
      exc_rep_r   <= 1'b0;
      pull_hit_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      closing_r   <= closing_nxt;
      taking_r    <= taking_nxt;
      seq_seen_r  <= seq_seen_nxt;
      next_seq_r  <= next_seq_nxt;
      fill_r      <= fill_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      remain_r    <= remain_nxt;
      urun_on_r   <= urun_on_nxt;
      urun_r      <= urun_nxt;
      ucount_r    <= ucount_nxt;
      exc_latch_r <= exc_latch_nxt;
      frames_r    <= frames_nxt;
      strobe_r    <= strobe_nxt;
      valid_r     <= valid_nxt;
      eos_r       <= eos_nxt;
      acc_r       <= acc_nxt;
      exc_rep_r   <= exc_rep_nxt;
      pull_hit_r  <= pull_hit_nxt;
    end
  end

  // concealment payload, no reset needed
  always_ff @(posedge clk) begin
    silcnt_r <= silcnt_nxt;
    flen_r   <= flen_nxt;
  end

  // configuration registers; writes land only while idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= ajrb_pkg::PREBUF_THR_RST;
      nom_r  <= ajrb_pkg::NOM_LEN_RST;
      maxc_r <= ajrb_pkg::MAX_CONCEAL_RST;
      ulim_r <= ajrb_pkg::UNDERRUN_LIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ajrb_pkg::REG_PREBUF_THR:   thr_r  <= cfg_data[14:0];
        ajrb_pkg::REG_NOM_LEN:      nom_r  <= cfg_data[14:0];
        ajrb_pkg::REG_MAX_CONCEAL:  maxc_r <= cfg_data[7:0];
        ajrb_pkg::REG_UNDERRUN_LIM: ulim_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Ring store and status
  // ---------------------------------------------------------------------------
  ajrb_ram #(
    .WIDTH (16),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  ajrb_pkg::status_t status;

  ajrb_status #(
    .RING_DEPTH (RING_DEPTH)
  ) u_status (
    .fill      (fill_r),
    .open      (open_r),
    .threshold (thr_r),
    .status    (status)
  );

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  // status is taken from live state: nothing moves it during a strobe cycle
  // before the edge that ends it
  assign busy                  = (state_r != ajrb_pkg::ST_IDLE);
  assign cfg_ready             = (state_r == ajrb_pkg::ST_IDLE);
  assign out_strobe            = strobe_r;
  assign out_sample_out        = pull_hit_r ? $signed(ram_rdata) : 16'sd0;
  assign out_sample_valid      = valid_r;
  assign out_end_of_stream     = eos_r;
  assign out_push_accepted     = acc_r;
  assign out_buffered_samples  = status.buffered;
  assign out_prebuffer_ready   = status.prebuf_ready;
  assign out_free_bytes        = status.free_bytes;
  assign out_underrun_events   = ucount_r;
  assign out_underrun_exceeded = exc_rep_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(RING_DEPTH))
    else $error("ring fill count above depth");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while sequencer busy");

  a_pull_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ajrb_pkg::ACT_PULL) && open_r && (fill_r != '0))
    |=> (out_strobe && out_sample_valid && !out_end_of_stream))
    else $error("pull on filled ring did not deliver a sample");

  a_conceal_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ajrb_pkg::ST_SIL_WRITE) |=> (fill_r == $past(fill_r) + FW'(1)))
    else $error("silence write did not advance fill");

endmodule

`default_nettype wire
